// ===== rtl/svv_pkg.sv =====
// ----------------------------------------------------------------------------
// svv_pkg
// Shared types and constants for the semantic version string checker.
// ----------------------------------------------------------------------------
package svv_pkg;

    localparam int unsigned COUNT_LIMIT_DEF = 255;
    localparam int unsigned NUM_W           = 64;
    localparam int unsigned CNT_W           = 8;
    localparam int unsigned CHAR_W          = 8;
    localparam int unsigned ERR_W           = 3;
    localparam int unsigned OUT_FIELDS_W    = ERR_W + 3 * NUM_W + 2 * CNT_W;
    localparam int unsigned OUT_TDATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7a;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5a;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;

    typedef enum logic [1:0] {
        SEC_CORE,
        SEC_PRE,
        SEC_BUILD
    } sec_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE,
        ERR_EMPTY,
        ERR_CORE,
        ERR_CORE_ZERO,
        ERR_OVERFLOW,
        ERR_EMPTY_ID,
        ERR_BAD_ID,
        ERR_PRE_ZERO
    } err_t;

    typedef struct packed {
        logic multi;
        logic first_zero;
        logic nondigit;
        logic invalid;
        logic nonempty;
    } id_flags_t;

    typedef struct packed {
        logic overflow;
        logic multi;
        logic first_zero;
        logic invalid;
        logic nonempty;
    } core_flags_t;

    typedef struct packed {
        logic [CNT_W-1:0] build_count;
        logic [CNT_W-1:0] prerelease_count;
        logic [NUM_W-1:0] patch_number;
        logic [NUM_W-1:0] minor_number;
        logic [NUM_W-1:0] major_number;
        err_t             error_code;
    } svv_result_t;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_id_char(input logic [CHAR_W-1:0] c);
        return is_digit(c) || ((c >= CH_LA) && (c <= CH_LZ)) ||
               ((c >= CH_UA) && (c <= CH_UZ)) || (c == CH_DASH);
    endfunction

endpackage

// ===== rtl/svv_engine.sv =====
// ----------------------------------------------------------------------------
// svv_engine
// Per-character parse state: section tracking, core number accumulation,
// identifier checks and the end-of-string verdict.
// ----------------------------------------------------------------------------
module svv_engine
    import svv_pkg::*;
#(
    parameter int unsigned COUNT_LIMIT = COUNT_LIMIT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [CHAR_W-1:0] char_byte,
    input  logic              has_char,
    input  logic              last,
    output svv_result_t       result
);

    localparam logic [CNT_W-1:0] CAP =
        CNT_W'((COUNT_LIMIT < 255) ? COUNT_LIMIT : 255);

    sec_t             sec_reg,   sec_next;
    logic             any_reg,   any_next;
    logic [1:0]       dot_reg,   dot_next;
    logic [NUM_W-1:0] val_reg    [3];
    logic [NUM_W-1:0] val_next   [3];
    core_flags_t      cfl_reg    [3];
    core_flags_t      cfl_next   [3];
    id_flags_t        ifl_reg,   ifl_next;
    err_t             perr_reg,  perr_next;
    err_t             berr_reg,  berr_next;
    logic             plus_reg,  plus_next;
    logic [CNT_W-1:0] cnt_reg    [2];
    logic [CNT_W-1:0] cnt_next   [2];

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        return (x < CAP) ? x + CNT_W'(1) : x;
    endfunction

    function automatic err_t id_error(input id_flags_t fl, input logic is_pre);
        if (!fl.nonempty) return ERR_EMPTY_ID;
        if (fl.invalid) return ERR_BAD_ID;
        if (is_pre && !fl.nondigit && fl.first_zero && fl.multi) return ERR_PRE_ZERO;
        return ERR_NONE;
    endfunction

    function automatic id_flags_t id_char(input id_flags_t fl, input logic [CHAR_W-1:0] c);
        id_flags_t r;
        r = fl;
        if (r.nonempty) r.multi = 1'b1;
        else if (c == CH_ZERO) r.first_zero = 1'b1;
        r.nonempty = 1'b1;
        if (!is_id_char(c)) r.invalid = 1'b1;
        if (!is_digit(c)) r.nondigit = 1'b1;
        return r;
    endfunction

    always_comb begin
        core_flags_t      fl;
        logic [1:0]       f;
        logic [NUM_W+3:0] prod;
        err_t             err;
        logic             done;
        err_t             pe;
        err_t             be;
        logic [CNT_W-1:0] c0;
        logic [CNT_W-1:0] c1;

        sec_next  = sec_reg;
        any_next  = any_reg;
        dot_next  = dot_reg;
        val_next  = val_reg;
        cfl_next  = cfl_reg;
        ifl_next  = ifl_reg;
        perr_next = perr_reg;
        berr_next = berr_reg;
        plus_next = plus_reg;
        cnt_next  = cnt_reg;
        f         = dot_reg;
        fl        = cfl_reg[0];
        prod      = '0;
        err       = ERR_NONE;
        done      = 1'b0;

        if (has_char) begin
            any_next = 1'b1;
            case (sec_reg)
                SEC_CORE: begin
                    if (char_byte == CH_DOT) begin
                        if (dot_reg != 2'd3) dot_next = dot_reg + 2'd1;
                    end else if (char_byte == CH_DASH) begin
                        sec_next = SEC_PRE;
                        ifl_next = '0;
                    end else if (char_byte == CH_PLUS) begin
                        sec_next = SEC_BUILD;
                        ifl_next = '0;
                    end else if (dot_reg != 2'd3) begin
                        fl = cfl_reg[f];
                        if (fl.nonempty) fl.multi = 1'b1;
                        else if (char_byte == CH_ZERO) fl.first_zero = 1'b1;
                        fl.nonempty = 1'b1;
                        if (!is_digit(char_byte)) begin
                            fl.invalid = 1'b1;
                        end else if (!fl.overflow) begin
                            prod = ({4'b0, val_reg[f]} << 3) + ({4'b0, val_reg[f]} << 1)
                                 + {{NUM_W{1'b0}}, 4'(char_byte - CH_ZERO)};
                            if (|prod[NUM_W+3:NUM_W]) fl.overflow = 1'b1;
                            else val_next[f] = prod[NUM_W-1:0];
                        end
                        cfl_next[f] = fl;
                    end
                end
                SEC_PRE: begin
                    if ((char_byte == CH_DOT) || (char_byte == CH_PLUS)) begin
                        if (perr_reg == ERR_NONE) perr_next = id_error(ifl_reg, 1'b1);
                        cnt_next[0] = sat_inc(cnt_reg[0]);
                        ifl_next    = '0;
                        if (char_byte == CH_PLUS) sec_next = SEC_BUILD;
                    end else begin
                        ifl_next = id_char(ifl_reg, char_byte);
                    end
                end
                default: begin
                    if (char_byte == CH_DOT) begin
                        if (berr_reg == ERR_NONE) berr_next = id_error(ifl_reg, 1'b0);
                        cnt_next[1] = sat_inc(cnt_reg[1]);
                        ifl_next    = '0;
                    end else if (char_byte == CH_PLUS) begin
                        plus_next = 1'b1;
                    end else begin
                        ifl_next = id_char(ifl_reg, char_byte);
                    end
                end
            endcase
        end

        // end of string: close the open identifier and pick the verdict
        pe = perr_next;
        be = berr_next;
        c0 = cnt_next[0];
        c1 = cnt_next[1];
        if (sec_next == SEC_PRE) begin
            if (pe == ERR_NONE) pe = id_error(ifl_next, 1'b1);
            c0 = sat_inc(c0);
        end else if (sec_next == SEC_BUILD) begin
            if (be == ERR_NONE) be = id_error(ifl_next, 1'b0);
            c1 = sat_inc(c1);
        end

        if (!any_next) begin
            err = ERR_EMPTY;
        end else if (plus_next) begin
            err = ERR_BAD_ID;
        end else if (be != ERR_NONE) begin
            err = be;
        end else if (pe != ERR_NONE) begin
            err = pe;
        end else if (dot_next != 2'd2) begin
            err = ERR_CORE;
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (!done) begin
                    if (!cfl_next[i].nonempty || cfl_next[i].invalid) begin
                        err  = ERR_CORE;
                        done = 1'b1;
                    end else if (cfl_next[i].first_zero && cfl_next[i].multi) begin
                        err  = ERR_CORE_ZERO;
                        done = 1'b1;
                    end else if (cfl_next[i].overflow) begin
                        err  = ERR_OVERFLOW;
                        done = 1'b1;
                    end
                end
            end
        end

        result.error_code = err;
        if (err == ERR_NONE) begin
            result.major_number     = val_next[0];
            result.minor_number     = val_next[1];
            result.patch_number     = val_next[2];
            result.prerelease_count = c0;
            result.build_count      = c1;
        end else begin
            result.major_number     = '0;
            result.minor_number     = '0;
            result.patch_number     = '0;
            result.prerelease_count = '0;
            result.build_count      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last)) begin
            sec_reg  <= SEC_CORE;
            any_reg  <= 1'b0;
            dot_reg  <= '0;
            val_reg  <= '{default: '0};
            cfl_reg  <= '{default: '0};
            ifl_reg  <= '0;
            perr_reg <= ERR_NONE;
            berr_reg <= ERR_NONE;
            plus_reg <= 1'b0;
            cnt_reg  <= '{default: '0};
        end else if (step) begin
            sec_reg  <= sec_next;
            any_reg  <= any_next;
            dot_reg  <= dot_next;
            val_reg  <= val_next;
            cfl_reg  <= cfl_next;
            ifl_reg  <= ifl_next;
            perr_reg <= perr_next;
            berr_reg <= berr_next;
            plus_reg <= plus_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== rtl/semver_string_validator_core.sv =====
// ----------------------------------------------------------------------------
// semver_string_validator_core
// Checks a semantic version string streamed one character per request.
// ----------------------------------------------------------------------------
// One character request is taken every cycle unless the input side stalls. Each
// request is captured in an input register, runs through the parse logic (one
// multiply-by-ten and add on the active core number) and, on tlast, the
// verdict is written into the output register. The input side stalls only
// when a tlast request finds the output register still holding a verdict that
// has not been taken.
module semver_string_validator_core
    import svv_pkg::*;
#(
    parameter int unsigned COUNT_LIMIT = COUNT_LIMIT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,  // char_byte
    input  logic                   s_tuser,  // has_char
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // error_code[2:0], major_number[66:3], minor_number[130:67],
    // patch_number[194:131], prerelease_count[202:195], build_count[210:203]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_has_reg;
    logic              in_last_reg;
    logic              advance;
    svv_result_t       res;
    logic              out_valid_reg, out_valid_next;
    svv_result_t       out_res_reg;

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_has_reg  <= s_tuser;
            in_last_reg <= s_tlast;
        end
    end

    svv_engine #(
        .COUNT_LIMIT(COUNT_LIMIT)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .char_byte (in_char_reg),
        .has_char  (in_has_reg),
        .last      (in_last_reg),
        .result    (res)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && in_last_reg) out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_res_reg};

endmodule

// ===== rtl/svv_checker.sv =====
// ----------------------------------------------------------------------------
// svv_checker
// Port-level checks for the version string checker, bound to the top level.
// ----------------------------------------------------------------------------
module svv_checker
    import svv_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[ERR_W-1:0] != ERR_NONE) |-> (m_tdata[OUT_FIELDS_W-1:ERR_W] == '0))
        else $error("error result carries nonzero fields");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] == '0))
        else $error("tdata padding not zero");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

endmodule

bind semver_string_validator_core svv_checker u_svv_checker (.*);

// ===== dv/semver_verdict_checker.sv =====
// ----------------------------------------------------------------------------
// semver_verdict_checker
// Watches both stream channels of the version string checker, tracks the
// parse of each string as its characters are accepted, and compares every
// verdict that leaves the block with the one predicted for its string.
// ----------------------------------------------------------------------------
module semver_verdict_checker
    import svv_pkg::*;
#(
    parameter int unsigned COUNT_LIMIT = COUNT_LIMIT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             s_tdata,  // char_byte
    input  logic                   s_tuser,  // has_char
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // error_code, major_number, minor_number, patch_number,
    // prerelease_count, build_count
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int unsigned            verdicts_due,
    output int unsigned            mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CAP = (COUNT_LIMIT < 255) ? COUNT_LIMIT : 255;

    sec_t             sec;
    logic             any_seen;
    logic [1:0]       dots;
    logic [NUM_W-1:0] core_val [3];
    core_flags_t      core_fl [3];
    id_flags_t        idf;
    err_t             pre_err;
    err_t             bld_err;
    logic             dup_plus;
    logic [CNT_W-1:0] ids [2];

    svv_result_t      verdict_q [$];
    int unsigned      errs;

    function automatic logic digit_char(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic name_char(input logic [7:0] c);
        return digit_char(c) || (c >= CH_LA && c <= CH_LZ) ||
               (c >= CH_UA && c <= CH_UZ) || c == CH_DASH;
    endfunction

    function automatic void clear_string();
        sec      = SEC_CORE;
        any_seen = 1'b0;
        dots     = '0;
        idf      = '0;
        pre_err  = ERR_NONE;
        bld_err  = ERR_NONE;
        dup_plus = 1'b0;
        for (int i = 0; i < 3; i++) begin
            core_val[i] = '0;
            core_fl[i]  = '0;
        end
        ids[0] = '0;
        ids[1] = '0;
    endfunction

    function automatic void close_ident();
        err_t e;
        e = ERR_NONE;
        if (!idf.nonempty) begin
            e = ERR_EMPTY_ID;
        end else if (idf.invalid) begin
            e = ERR_BAD_ID;
        end else if (sec == SEC_PRE && !idf.nondigit && idf.first_zero && idf.multi) begin
            e = ERR_PRE_ZERO;
        end
        if (sec == SEC_PRE) begin
            if (pre_err == ERR_NONE) pre_err = e;
            if (ids[0] < CAP) ids[0] = ids[0] + 1'b1;
        end else begin
            if (bld_err == ERR_NONE) bld_err = e;
            if (ids[1] < CAP) ids[1] = ids[1] + 1'b1;
        end
        idf = '0;
    endfunction

    function automatic void ident_char(input logic [7:0] c);
        if (idf.nonempty) begin
            idf.multi = 1'b1;
        end else if (c == CH_ZERO) begin
            idf.first_zero = 1'b1;
        end
        idf.nonempty = 1'b1;
        if (!name_char(c)) idf.invalid = 1'b1;
        if (!digit_char(c)) idf.nondigit = 1'b1;
    endfunction

    function automatic void core_char(input logic [7:0] c);
        logic [NUM_W-1:0] d;
        logic [NUM_W-1:0] lim;
        int               f;
        if (dots > 2'd2) return;
        f = dots;
        if (core_fl[f].nonempty) begin
            core_fl[f].multi = 1'b1;
        end else if (c == CH_ZERO) begin
            core_fl[f].first_zero = 1'b1;
        end
        core_fl[f].nonempty = 1'b1;
        if (!digit_char(c)) begin
            core_fl[f].invalid = 1'b1;
            return;
        end
        if (!core_fl[f].overflow) begin
            d   = NUM_W'(c) - NUM_W'(CH_ZERO);
            lim = ({NUM_W{1'b1}} - d) / NUM_W'(10);
            if (core_val[f] > lim) begin
                core_fl[f].overflow = 1'b1;
            end else begin
                core_val[f] = core_val[f] * NUM_W'(10) + d;
            end
        end
    endfunction

    function automatic void take_char(input logic [7:0] c);
        any_seen = 1'b1;
        case (sec)
            SEC_CORE: begin
                if (c == CH_DOT) begin
                    if (dots < 2'd3) dots = dots + 1'b1;
                end else if (c == CH_DASH) begin
                    sec = SEC_PRE;
                    idf = '0;
                end else if (c == CH_PLUS) begin
                    sec = SEC_BUILD;
                    idf = '0;
                end else begin
                    core_char(c);
                end
            end
            SEC_PRE: begin
                if (c == CH_DOT) begin
                    close_ident();
                end else if (c == CH_PLUS) begin
                    close_ident();
                    sec = SEC_BUILD;
                    idf = '0;
                end else begin
                    ident_char(c);
                end
            end
            default: begin
                if (c == CH_DOT) begin
                    close_ident();
                end else if (c == CH_PLUS) begin
                    dup_plus = 1'b1;
                end else begin
                    ident_char(c);
                end
            end
        endcase
    endfunction

    function automatic err_t core_verdict();
        if (dots != 2'd2) return ERR_CORE;
        for (int i = 0; i < 3; i++) begin
            if (!core_fl[i].nonempty || core_fl[i].invalid) return ERR_CORE;
            if (core_fl[i].first_zero && core_fl[i].multi) return ERR_CORE_ZERO;
            if (core_fl[i].overflow) return ERR_OVERFLOW;
        end
        return ERR_NONE;
    endfunction

    function automatic svv_result_t close_string();
        svv_result_t r;
        err_t        e;
        r = '0;
        if (sec != SEC_CORE) close_ident();
        if (!any_seen) begin
            e = ERR_EMPTY;
        end else if (dup_plus) begin
            e = ERR_BAD_ID;
        end else if (bld_err != ERR_NONE) begin
            e = bld_err;
        end else if (pre_err != ERR_NONE) begin
            e = pre_err;
        end else begin
            e = core_verdict();
        end
        r.error_code = e;
        if (e == ERR_NONE) begin
            r.major_number     = core_val[0];
            r.minor_number     = core_val[1];
            r.patch_number     = core_val[2];
            r.prerelease_count = ids[0];
            r.build_count      = ids[1];
        end
        clear_string();
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [NUM_W-1:0] want,
                                        input logic [NUM_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errs++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        svv_result_t want;
        svv_result_t got;
        if (!aresetn) begin
            clear_string();
            verdict_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                if (s_tuser) take_char(s_tdata);
                if (s_tlast) verdict_q.insert(verdict_q.size(), close_string());
            end
            if (m_tvalid && m_tready) begin
                got = svv_result_t'(m_tdata[OUT_FIELDS_W-1:0]);
                if (verdict_q.size() == 0) begin
                    $display("%0t ns: verdict with none due, expected none, actual error_code %0d",
                             $time, got.error_code);
                    errs++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("error_code", NUM_W'(want.error_code), NUM_W'(got.error_code));
                    check_field("major_number", want.major_number, got.major_number);
                    check_field("minor_number", want.minor_number, got.minor_number);
                    check_field("patch_number", want.patch_number, got.patch_number);
                    check_field("prerelease_count", NUM_W'(want.prerelease_count),
                                NUM_W'(got.prerelease_count));
                    check_field("build_count", NUM_W'(want.build_count),
                                NUM_W'(got.build_count));
                end
            end
        end
        verdicts_due <= verdict_q.size();
        mismatches   <= errs;
    end

endmodule

// ===== dv/tb_semver_string_validator_core.sv =====
// ----------------------------------------------------------------------------
// tb_semver_string_validator_core
// Streams version strings into the checker block: directed strings for the
// edges of the grammar, then random strings, mostly well formed with some
// broken and some pure noise, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_semver_string_validator_core
    import svv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int unsigned verdicts_due;
    int unsigned mismatches;

    bit          calm = 1'b0;
    int unsigned items_sent;
    logic [7:0]  txt [$];

    string name_set = "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ-";

    semver_string_validator_core #(
        .COUNT_LIMIT(COUNT_LIMIT_DEF)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    semver_verdict_checker #(
        .COUNT_LIMIT(COUNT_LIMIT_DEF)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .verdicts_due(verdicts_due),
        .mismatches  (mismatches)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        forever begin
            @(posedge aclk);
            m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 27);
        end
    end

    task automatic send_item(input logic [7:0] c, input logic has, input logic fin);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= has;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (!calm && $urandom_range(0, 99) < 15) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic send_text(input bit bare_end);
        int n;
        n = txt.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 4) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(txt[i], 1'b1, !bare_end && i == n - 1);
        end
        if (bare_end || n == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        txt.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (verdicts_due != 0);
    endtask

    task automatic append_char(input logic [7:0] c);
        txt.insert(txt.size(), c);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) append_char(s[i]);
    endtask

    task automatic add_core_num();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: add_str($sformatf("%0d", $urandom_range(0, 99)));
            4: add_str($sformatf("%0d", $urandom));
            5: add_str($sformatf("%0d", {$urandom, $urandom}));
            6: add_str($sformatf("1844674407370955161%0d", $urandom_range(4, 9)));
            7: add_str($sformatf("0%0d", $urandom_range(0, 999)));
            8: add_str("0");
            default: repeat ($urandom_range(15, 22)) append_char(name_set[$urandom_range(0, 9)]);
        endcase
    endtask

    task automatic add_ident();
        case ($urandom_range(0, 9))
            0, 1, 2: add_str($sformatf("%0d", $urandom_range(0, 999)));
            3: add_str($sformatf("0%0d", $urandom_range(0, 99)));
            4: add_str("0");
            default: repeat ($urandom_range(1, 6))
                append_char(name_set[$urandom_range(0, name_set.len() - 1)]);
        endcase
    endtask

    task automatic add_ident_list();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            if (i != 0) append_char(CH_DOT);
            add_ident();
        end
    endtask

    task automatic make_text();
        int unsigned k;
        int unsigned pos;
        k = $urandom_range(0, 99);
        if (k < 4) return;
        if (k < 14) begin
            repeat ($urandom_range(1, 12))
                append_char(($urandom_range(0, 3) == 0) ? CH_DOT : 8'($urandom_range(0, 255)));
            return;
        end
        add_core_num();
        append_char(CH_DOT);
        add_core_num();
        append_char(CH_DOT);
        add_core_num();
        if ($urandom_range(0, 99) < 45) begin
            append_char(CH_DASH);
            add_ident_list();
        end
        if ($urandom_range(0, 99) < 40) begin
            append_char(CH_PLUS);
            add_ident_list();
        end
        if (k >= 76) begin
            repeat ($urandom_range(1, 2)) begin
                pos = $urandom_range(0, txt.size() - 1);
                case ($urandom_range(0, 5))
                    0: txt[pos] = 8'($urandom_range(0, 255));
                    1: txt.delete(pos);
                    2: txt.insert(pos, CH_DOT);
                    3: txt.insert(pos, CH_PLUS);
                    4: txt.insert(pos, CH_DASH);
                    default: append_char(CH_DOT);
                endcase
                if (txt.size() == 0) append_char(CH_ZERO);
            end
        end
    endtask

    initial begin : stimulus
        string       dir_cases [$];
        int unsigned strings_sent;
        int unsigned guard;
        dir_cases = '{
            "1.2.3", "0.0.0",
            "18446744073709551615.18446744073709551615.18446744073709551615",
            "18446744073709551616.0.0", "1.99999999999999999999.0",
            "01.2.3", "1.00.3", "1.2", "1.2.3.4", "1.a.3", "1..3",
            "1.2.3-alpha.1+build.007", "1.2.3-01", "1.2.3-0a.0.-Z9",
            "1.2.3-a..b", "1.2.3-a$b", "1.2.3+a+b", "1.2.3-", "1.2.3+",
            "1.2.3-x+b!", "01.2.3-a+b", "1.2.3-01+."
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_cases[i]) begin
            add_str(dir_cases[i]);
            send_text(1'b0);
        end
        send_text(1'b1);
        add_str("1.2.3-rc");
        send_text(1'b1);
        append_char(8'hff);
        append_char(8'h80);
        append_char(8'h7f);
        send_text(1'b0);
        // identifier counts past saturation
        add_str("1.2.3-a");
        repeat (258) add_str(".b");
        add_str("+c");
        repeat (258) add_str(".0");
        send_text(1'b0);
        drain();

        strings_sent = 0;
        while (items_sent < 1750) begin
            calm = strings_sent >= 3 && strings_sent < 9;
            make_text();
            send_text($urandom_range(0, 99) < 15);
            strings_sent++;
            if (strings_sent % 60 == 0) drain();
        end
        calm = 1'b0;

        s_tvalid <= 1'b0;
        guard = 0;
        do begin
            @(posedge aclk);
            guard++;
        end while (verdicts_due != 0 && guard < 20000);
        repeat (10) @(posedge aclk);
        if (verdicts_due == 0 && mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/svv_pkg.sv
rtl/svv_engine.sv
rtl/semver_string_validator_core.sv
rtl/svv_checker.sv
dv/semver_verdict_checker.sv
dv/tb_semver_string_validator_core.sv
